### sv/khdd_pkg.sv
// shared constants and types for the highest differing digit block
`default_nettype none

package khdd_pkg;

   // sizing
   localparam int MAX_DIGITS = 16;
   localparam int NODE_BITS  = 16;
   localparam int NODE_W     = 16;
   localparam int REG_W      = 5;
   localparam int DIGIT_W    = 5;
   localparam int LEVEL_W    = 4;
   localparam int CSR_IDX_W  = 1;

   // node bits that survive the input mask
   localparam int SHIFT_BITS = (NODE_BITS < NODE_W) ? NODE_BITS : NODE_W;
   localparam int CNT_W      = $clog2(SHIFT_BITS + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DIGITS = 1'b1;

   // register reset values and radix floor
   localparam logic [REG_W-1:0] RADIX_RESET      = 5'd4;
   localparam logic [REG_W-1:0] NUM_DIGITS_RESET = 5'd3;
   localparam logic [REG_W-1:0] RADIX_MIN        = 5'd2;

   typedef logic [DIGIT_W-1:0] digit_type;

   // carry pair passed between neighboring cells, one per node
   typedef struct packed {
      logic a;
      logic b;
   } carry_type;

   // per-cycle control broadcast to the cell row
   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### sv/khdd_if.sv
// request and response channel interfaces
`default_nettype none

interface khdd_req_if;
   logic                        valid;
   logic                        ready;
   logic [khdd_pkg::NODE_W-1:0] first_node;
   logic [khdd_pkg::NODE_W-1:0] second_node;

   modport source (output valid, first_node, second_node, input ready);
   modport sink   (input valid, first_node, second_node, output ready);
endinterface

interface khdd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [khdd_pkg::LEVEL_W-1:0] differ_level;

   modport source (output valid, differ_level, input ready);
   modport sink   (input valid, differ_level, output ready);
endinterface

`default_nettype wire

### sv/khdd_digit_cell.sv
// one radix-k digit of both nodes, doubled and carried each shift cycle
`default_nettype none

module khdd_digit_cell (
   input  logic                    clock,
   input  khdd_pkg::cell_ctrl_type ctrl,
   input  khdd_pkg::digit_type     radix,
   input  khdd_pkg::carry_type     carry_in,
   output khdd_pkg::carry_type     carry_out,
   output logic                    mismatch
);
   import khdd_pkg::*;

   digit_type             a_ff, a_in;
   digit_type             b_ff, b_in;
   logic [DIGIT_W:0]      a_step, b_step;

   // digit * 2 + carry in, folded back below radix; carry out when it wraps
   function automatic logic [DIGIT_W:0] dbl_step(digit_type d, logic cin, digit_type k);
      logic [DIGIT_W:0] v;
      logic             g;
      logic             p;
      logic             c;
      v = {d, cin};
      g = ({d, 1'b0} >= {1'b0, k});
      p = ({d, 1'b1} == {1'b0, k});
      c = g | (p & cin);
      v = v - (c ? {1'b0, k} : '0);
      return {c, v[DIGIT_W-1:0]};
   endfunction

   assign a_step = dbl_step(a_ff, carry_in.a, radix);
   assign b_step = dbl_step(b_ff, carry_in.b, radix);

   assign carry_out.a = a_step[DIGIT_W];
   assign carry_out.b = b_step[DIGIT_W];

   // next digit values
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (ctrl.clear) begin
         a_in = '0;
         b_in = '0;
      end else if (ctrl.shift) begin
         a_in = a_step[DIGIT_W-1:0];
         b_in = b_step[DIGIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign mismatch = (a_ff != b_ff);

endmodule

`default_nettype wire

### sv/khdd_level_enc.sv
// picks the highest differing digit position below the digit count
`default_nettype none

module khdd_level_enc (
   input  logic [khdd_pkg::MAX_DIGITS-1:0] mismatch,
   input  logic [khdd_pkg::REG_W-1:0]      num_digits,
   output logic [khdd_pkg::LEVEL_W-1:0]    level
);
   import khdd_pkg::*;

   // digit 0 never counts; later positions override earlier ones
   always_comb begin
      level = '0;
      for (int i = 1; i < MAX_DIGITS; i++) begin
         if (mismatch[i] && (REG_W'(i) < num_digits)) begin
            level = LEVEL_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

### sv/kary_highest_differing_digit.sv
// Highest differing radix-k digit of two node numbers.
// From request acceptance to a valid response: cells cleared at acceptance, the node bits
// shifted msb first through the digit cell row, then one compare step.
// The next request is taken once the previous result has moved to the output register; a
// response waiting there does not hold off the next request, but stalls the next compare.
// Reset (synchronous, active high): radix 4, num_digits 3, idle, no response pending.
`default_nettype none

module kary_highest_differing_digit (
   input  logic                              clock,
   input  logic                              reset,
   khdd_req_if.sink                          req_ch,
   khdd_rsp_if.source                        rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [khdd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [khdd_pkg::REG_W-1:0]        csr_wdata
);
   import khdd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_RUN    = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [REG_W-1:0]        radix_ff, radix_in;
   logic [REG_W-1:0]        num_digits_ff, num_digits_in;
   logic [SHIFT_BITS-1:0]   a_sh_ff, a_sh_in;
   logic [SHIFT_BITS-1:0]   b_sh_ff, b_sh_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]      level_ff, level_in;

   logic                    req_acc;
   logic                    load_rsp;
   digit_type               radix_eff;
   cell_ctrl_type           ctrl;
   carry_type               carry [MAX_DIGITS+1];
   logic [MAX_DIGITS-1:0]   mismatch;
   logic [LEVEL_W-1:0]      level_enc;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid & req_ch.ready;
   assign load_rsp     = (state_ff == ST_FINISH) & (~rsp_valid_ff | rsp_ch.ready);

   // radix below two behaves as two
   assign radix_eff = (radix_ff < RADIX_MIN) ? RADIX_MIN : radix_ff;

   // configuration registers
   always_comb begin
      radix_in      = radix_ff;
      num_digits_in = num_digits_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_RADIX:      radix_in      = csr_wdata;
            CSR_NUM_DIGITS: num_digits_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer: clear, shift node bits msb first, then compare
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      a_sh_in  = a_sh_ff;
      b_sh_in  = b_sh_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               a_sh_in  = req_ch.first_node[SHIFT_BITS-1:0];
               b_sh_in  = req_ch.second_node[SHIFT_BITS-1:0];
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            a_sh_in = a_sh_ff << 1;
            b_sh_in = b_sh_ff << 1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SHIFT_BITS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign ctrl.clear = req_acc;
   assign ctrl.shift = (state_ff == ST_RUN);

   // digit cell row, carries ripple from digit 0 upward
   assign carry[0].a = a_sh_ff[SHIFT_BITS-1];
   assign carry[0].b = b_sh_ff[SHIFT_BITS-1];

   for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
      khdd_digit_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .radix     (radix_eff),
         .carry_in  (carry[g]),
         .carry_out (carry[g+1]),
         .mismatch  (mismatch[g])
      );
   end

   khdd_level_enc u_enc (
      .mismatch   (mismatch),
      .num_digits (num_digits_ff),
      .level      (level_enc)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      level_in     = level_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         level_in     = level_enc;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.differ_level = level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         radix_ff      <= RADIX_RESET;
         num_digits_ff <= NUM_DIGITS_RESET;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         radix_ff      <= radix_in;
         num_digits_ff <= num_digits_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sh_ff  <= a_sh_in;
      b_sh_ff  <= b_sh_in;
      level_ff <= level_in;
   end

endmodule

`default_nettype wire

### sv/khdd_checker.sv
// port-level checks for the highest differing digit block
`default_nettype none

module khdd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [khdd_pkg::LEVEL_W-1:0]     rsp_level
);

   // a pending response stays up until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // a stalled response keeps its level
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_level))
      else $error("response level changed while stalled");

   // request side closes while a transaction is being worked on
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous transaction in flight");

   // a new response only comes out of the compare step, never from idle
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a finished transaction");

endmodule

bind kary_highest_differing_digit khdd_checker u_khdd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_level (rsp_ch.differ_level)
);

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for the highest differing digit block
`timescale 1ns / 1ps

module testbench;
   import khdd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned GAP_PERCENT = 13;
   localparam int unsigned NODE_MASK   = (NODE_BITS >= 32) ? 32'hFFFF_FFFF
                                                          : (32'd1 << NODE_BITS) - 1;

   typedef struct {
      logic [NODE_W-1:0] first;
      logic [NODE_W-1:0] second;
   } node_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_wdata;

   khdd_req_if req_ch ();
   khdd_rsp_if rsp_ch ();

   kary_highest_differing_digit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the block's registers
   logic [REG_W-1:0] radix_reg  = RADIX_RESET;
   logic [REG_W-1:0] digits_reg = NUM_DIGITS_RESET;

   node_pair_type      pending_pairs[$];
   logic [LEVEL_W-1:0] expected_levels[$];
   int unsigned        error_count = 0;
   int unsigned        cycle_count = 0;
   logic               no_gaps = 1'b0;

   always #5 clock = ~clock;

   // highest digit position where the two nodes differ
   function automatic logic [LEVEL_W-1:0] differ_level_of(logic [NODE_W-1:0] a,
                                                          logic [NODE_W-1:0] b);
      int unsigned base;
      int unsigned count;
      int unsigned x;
      int unsigned y;
      logic [LEVEL_W-1:0] level;
      base  = (radix_reg < RADIX_MIN) ? RADIX_MIN : radix_reg;
      count = (digits_reg == 0) ? 1 : digits_reg;
      if (count > MAX_DIGITS) count = MAX_DIGITS;
      x = a & NODE_MASK;
      y = b & NODE_MASK;
      level = '0;
      for (int i = 0; i < count; i++) begin
         if ((x % base) != (y % base)) level = i[LEVEL_W-1:0];
         x = x / base;
         y = y / base;
      end
      return level;
   endfunction

   function automatic bit take_gap();
      return !no_gaps && ($urandom_range(0, 99) < GAP_PERCENT);
   endfunction

   // request driver
   always @(posedge clock) begin : req_driver
      node_pair_type next_pair;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_pairs.size() != 0 && !take_gap()) begin
            next_pair = pending_pairs.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.first_node  <= next_pair.first;
            req_ch.second_node <= next_pair.second;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // predict the level of each accepted request
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         expected_levels.push_back(differ_level_of(req_ch.first_node, req_ch.second_node));
   end

   // response back-pressure
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else       rsp_ch.ready <= !take_gap();
   end

   // response monitor and checker
   always @(posedge clock) begin : rsp_monitor
      logic [LEVEL_W-1:0] want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_levels.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, actual differ_level %0d",
                     $time, rsp_ch.differ_level);
            error_count++;
         end else begin
            want = expected_levels.pop_front();
            if (rsp_ch.differ_level !== want) begin
               $display("%0t: differ_level mismatch: expected %0d, actual %0d",
                        $time, want, rsp_ch.differ_level);
               error_count++;
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_RADIX) radix_reg = val;
      else                  digits_reg = val;
   endtask

   task automatic set_config(input logic [REG_W-1:0] radix_val,
                             input logic [REG_W-1:0] digits_val);
      write_csr(CSR_RADIX, radix_val);
      write_csr(CSR_NUM_DIGITS, digits_val);
      @(negedge clock);
   endtask

   task automatic queue_pair(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
      node_pair_type pair;
      pair.first  = a;
      pair.second = b;
      pending_pairs.push_back(pair);
   endtask

   // wait until every transaction has been sent and answered
   task automatic drain();
      do @(negedge clock);
      while (pending_pairs.size() != 0 || req_ch.valid || expected_levels.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // mostly related node pairs, some unrelated noise
   task automatic queue_random(input int unsigned count);
      logic [31:0] a;
      logic [31:0] b;
      int unsigned width;
      for (int i = 0; i < count; i++) begin
         a = $urandom;
         case ($urandom_range(0, 9))
            0: b = a;
            1, 2, 3, 4, 5: begin
               width = $urandom_range(0, NODE_W);
               b = a ^ ($urandom & ((32'd1 << width) - 1));
            end
            6, 7: b = a + $urandom_range(1, 300);
            default: b = $urandom;
         endcase
         queue_pair(a[NODE_W-1:0], b[NODE_W-1:0]);
      end
   endtask

   // stimulus sequence
   initial begin
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.first_node  = '0;
      req_ch.second_node = '0;
      rsp_ch.ready       = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed items at the reset setting: radix 4, three digits
      queue_pair(16'h0000, 16'h0000);
      queue_pair(16'hFFFF, 16'hFFFF);
      queue_pair(16'h0000, 16'hFFFF);
      queue_pair(16'hFFFF, 16'h0000);
      queue_pair(16'd1, 16'd0);
      queue_pair(16'd4, 16'd0);
      queue_pair(16'd16, 16'd0);
      queue_pair(16'd64, 16'd0);
      drain();

      // radix below two, above sixteen, zero and too many digits, extremes
      set_config(5'd0, 5'd5);
      queue_pair(16'h0000, 16'hFFFF);
      queue_pair(16'h8000, 16'h7FFF);
      drain();
      set_config(5'd1, 5'd16);
      queue_pair(16'h0000, 16'hFFFF);
      queue_pair(16'h8000, 16'h7FFF);
      drain();
      set_config(5'd17, 5'd2);
      queue_pair(16'h0000, 16'hFFFF);
      queue_pair(16'h8000, 16'h7FFF);
      drain();
      set_config(5'd31, 5'd16);
      queue_pair(16'h0000, 16'hFFFF);
      queue_pair(16'h8000, 16'h7FFF);
      drain();
      set_config(5'd3, 5'd0);
      queue_pair(16'h0000, 16'hFFFF);
      queue_pair(16'h8000, 16'h7FFF);
      drain();
      set_config(5'd2, 5'd31);
      queue_pair(16'h0000, 16'hFFFF);
      queue_pair(16'h8000, 16'h7FFF);
      drain();
      set_config(5'd16, 5'd16);
      queue_pair(16'h0000, 16'hFFFF);
      queue_pair(16'h8000, 16'h7FFF);
      drain();
      set_config(5'd2, 5'd1);
      queue_pair(16'h0000, 16'hFFFF);
      queue_pair(16'h8000, 16'h7FFF);
      drain();

      // random phases, mostly in the meaningful range, one without gaps
      for (int p = 0; p < 10; p++) begin
         if (p % 3 == 2) set_config(REG_W'($urandom_range(0, 31)),
                                    REG_W'($urandom_range(0, 31)));
         else            set_config(REG_W'($urandom_range(2, 16)),
                                    REG_W'($urandom_range(1, 16)));
         no_gaps = (p == 4);
         queue_random(95);
         drain();
      end
      no_gaps = 1'b0;

      repeat (25) @(negedge clock);
      if (error_count == 0 && expected_levels.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
sv/khdd_pkg.sv
sv/khdd_if.sv
sv/khdd_digit_cell.sv
sv/khdd_level_enc.sv
sv/kary_highest_differing_digit.sv
sv/khdd_checker.sv
tb/testbench.sv
